### design/msq_pkg.sv
// ----------------------------------------------------------------------------
// msq_pkg: motion sequence engine types and codes
// Item formats, function codes, phase/stage codes, sequence ids and
// configuration register indexes shared by the engine.
// ----------------------------------------------------------------------------
package msq_pkg;

  // Function codes of an input item
  localparam logic [1:0] FN_TICK   = 2'd0;
  localparam logic [1:0] FN_SELECT = 2'd1;
  localparam logic [1:0] FN_LOAD   = 2'd2;

  // Phase machine codes
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_MOVE   = 3'd1;
  localparam logic [2:0] PH_WAIT   = 3'd2;
  localparam logic [2:0] PH_NEXT   = 3'd3;
  localparam logic [2:0] PH_CHANGE = 3'd4;

  // Sequence stage codes
  localparam logic [1:0] ST_PREPARE  = 2'd0;
  localparam logic [1:0] ST_MAIN     = 2'd1;
  localparam logic [1:0] ST_FINALIZE = 2'd2;

  // Sequence ids
  localparam logic [3:0] SQ_NONE      = 4'd0;
  localparam logic [3:0] SQ_UP        = 4'd1;
  localparam logic [3:0] SQ_DOWN      = 4'd2;
  localparam logic [3:0] SQ_DIRECT    = 4'd3;
  localparam logic [3:0] SQ_REVERSE   = 4'd4;
  localparam logic [3:0] SQ_PUSH_PULL = 4'd6;
  localparam logic [3:0] SQ_DANCE     = 4'd9;
  localparam logic [3:0] SQ_LAST      = 4'd11;

  // Fixed trajectory of the push/pull sequence
  localparam logic signed [15:0] PUSH_PULL_CURV = 16'sd1;
  localparam logic signed [15:0] PUSH_PULL_STEP = 16'sd110;

  // Configuration registers
  localparam logic [1:0] CFG_IDLE_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_SPEED = 2'd1;

  localparam logic [31:0] IDLE_TIMEOUT_RST  = 32'd20000;
  localparam logic [15:0] DEFAULT_SPEED_RST = 16'd0;

  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        now_ms;
    logic               motion_done;
    logic [3:0]         sequence_req;
    logic [15:0]        speed;
    logic signed [15:0] curvature;
    logic signed [15:0] stride;
    logic [7:0]         main_begin;
    logic [7:0]         finalize_begin;
    logic [7:0]         total_motions;
    logic               looped;
  } msq_in_t;

  typedef struct packed {
    logic               start_motion;
    logic [3:0]         motion_sequence;
    logic [7:0]         motion_index;
    logic               speed_write;
    logic [15:0]        speed_value;
    logic               trajectory_write;
    logic signed [15:0] out_curvature;
    logic signed [15:0] out_stride;
    logic               trajectory_reset;
    logic               fatal_error;
    logic               body_up;
    logic [2:0]         engine_phase;
  } msq_out_t;

endpackage

### design/motion_sequence_engine_unit.sv
// ----------------------------------------------------------------------------
// motion_sequence_engine_unit: motion sequence engine
// Sequences the motions of a legged robot from a table of sequence
// descriptors, driven by select, load and tick items.
// ----------------------------------------------------------------------------
// The engine takes one item per clock while no result stall holds its execute
// register and returns exactly one result item for each, through the execute
// register and then the output register. An accepted item first sits in the
// execute register while the descriptor table, a synchronous memory, is read
// at the entry of the sequence that will be active when the item executes.
// Once the output register is free or being emptied, the item executes: the
// phase machine, the select logic and the table write all act at once and the
// result is loaded into the output register. A load that executes at the same
// edge as the read of the same entry is forwarded to the item behind it. The
// table is not cleared after reset; a sequence must be loaded before the engine
// runs it. Configuration writes (idle timeout, default speed) are always taken
// and must only be issued while the engine is idle.
// ----------------------------------------------------------------------------
module motion_sequence_engine_unit
  import msq_pkg::*;
#(
  parameter int NUM_SEQUENCES = 16,
  parameter int INDEX_BITS    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  msq_in_t     in_data,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output msq_out_t    out_data,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW  = $clog2(NUM_SEQUENCES);
  localparam int IDW = (AW + 1 > 4) ? AW + 1 : 4;
  localparam int DW  = 3 * INDEX_BITS + 1;

  // ---- configuration registers ----
  logic [31:0] idle_timeout_r;
  logic [15:0] default_speed_r;

  // ---- engine state ----
  logic [2:0]            phase_r;
  logic [1:0]            stage_r;
  logic [INDEX_BITS-1:0] cnt_r;
  logic [3:0]            active_r;
  logic [3:0]            pending_r;
  logic                  up_r;
  logic [31:0]           last_r;
  logic                  dis_r;

  // ---- pipeline ----
  logic     s1_v_r;
  msq_in_t  s1_r;
  logic     out_v_r;
  msq_out_t out_r;

  // ---- descriptor memory ----
  logic [DW-1:0] mem [NUM_SEQUENCES];
  logic [DW-1:0] rd_word_r;
  logic [DW-1:0] fwd_word_r;
  logic          fwd_v_r;
  logic          rd_zero_r;

  logic in_acc;
  logic exec;

  // execute results
  logic [2:0]            p_phase;
  logic [1:0]            p_stage;
  logic [INDEX_BITS-1:0] p_cnt;
  logic [3:0]            p_active;
  logic [3:0]            p_pending;
  logic                  p_up;
  logic [31:0]           p_last;
  logic                  p_dis;
  msq_out_t              res;

  logic                  wr_en;
  logic                  wr_fire;
  logic [IDW-1:0]        wr_id;
  logic [DW-1:0]         wr_word;

  logic [3:0]            rd_seq;
  logic [IDW-1:0]        rd_id;
  logic                  rd_in;

  logic [DW-1:0]         desc;
  logic [INDEX_BITS-1:0] d_mb;
  logic [INDEX_BITS-1:0] d_fb;
  logic [INDEX_BITS-1:0] d_tot;
  logic                  d_loop;

  // ---- handshakes ----
  // Execute when the output register is free or being emptied this cycle.
  assign exec      = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall  = s1_v_r && !exec;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // ---- descriptor of the executing item ----
  always_comb begin
    if (rd_zero_r) begin
      desc = '0;
    end else if (fwd_v_r) begin
      desc = fwd_word_r;
    end else begin
      desc = rd_word_r;
    end
  end

  assign d_mb   = desc[INDEX_BITS-1:0];
  assign d_fb   = desc[2*INDEX_BITS-1:INDEX_BITS];
  assign d_tot  = desc[3*INDEX_BITS-1:2*INDEX_BITS];
  assign d_loop = desc[DW-1];

  // ---- table write of a load ----
  assign wr_id   = IDW'(s1_r.sequence_req);
  assign wr_word = {s1_r.looped,
                    INDEX_BITS'(s1_r.total_motions),
                    INDEX_BITS'(s1_r.finalize_begin),
                    INDEX_BITS'(s1_r.main_begin)};
  assign wr_fire = exec && wr_en;

  // ---- execute: phase machine, select logic ----
  always_comb begin
    logic                  sel_en;
    logic [3:0]            sel_seq;
    logic [15:0]           sel_spd;
    logic signed [15:0]    sel_curv;
    logic signed [15:0]    sel_step;
    logic [INDEX_BITS-1:0] cnt_inc;
    logic [31:0]           idle_ms;

    p_phase   = phase_r;
    p_stage   = stage_r;
    p_cnt     = cnt_r;
    p_active  = active_r;
    p_pending = pending_r;
    p_up      = up_r;
    p_last    = last_r;
    p_dis     = dis_r;
    res       = '0;
    wr_en     = 1'b0;
    sel_en    = 1'b0;
    sel_seq   = s1_r.sequence_req;
    sel_spd   = s1_r.speed;
    sel_curv  = s1_r.curvature;
    sel_step  = s1_r.stride;
    cnt_inc   = cnt_r + INDEX_BITS'(1);
    idle_ms   = s1_r.now_ms - last_r;

    unique case (s1_r.func)
      FN_TICK: begin
        if (!dis_r) begin
          unique case (phase_r)
            PH_IDLE: begin
              if (active_r != pending_r) begin
                p_phase = PH_CHANGE;
              end else if (idle_ms > idle_timeout_r) begin
                // idle too long: lower the body
                sel_en   = 1'b1;
                sel_seq  = SQ_DOWN;
                sel_spd  = '0;
                sel_curv = '0;
                sel_step = '0;
              end
            end
            PH_MOVE: begin
              res.start_motion    = 1'b1;
              res.motion_sequence = active_r;
              res.motion_index    = 8'(cnt_r);
              p_phase             = PH_WAIT;
            end
            PH_WAIT: begin
              if (s1_r.motion_done) begin
                p_phase = PH_NEXT;
              end
            end
            PH_NEXT: begin
              p_cnt   = cnt_inc;
              p_phase = PH_MOVE;
              if (p_stage == ST_PREPARE && p_cnt >= d_mb) begin
                p_stage = ST_MAIN;
              end
              if (p_stage == ST_MAIN && p_cnt >= d_fb) begin
                if (active_r != pending_r) begin
                  // change requested: jump to the finalize part
                  p_cnt   = d_fb;
                  p_stage = ST_FINALIZE;
                end else if (d_loop) begin
                  p_cnt = d_mb;
                end else begin
                  p_pending = SQ_NONE;
                  p_phase   = PH_CHANGE;
                end
              end
              if (p_stage == ST_FINALIZE && p_cnt >= d_tot) begin
                p_phase = PH_CHANGE;
                p_up    = (active_r != SQ_DOWN);
              end
            end
            PH_CHANGE: begin
              p_active             = pending_r;
              p_cnt                = '0;
              p_stage              = ST_PREPARE;
              p_phase              = PH_MOVE;
              res.trajectory_reset = 1'b1;
              if (pending_r == SQ_NONE) begin
                p_phase = PH_IDLE;
                p_last  = s1_r.now_ms;
              end
            end
            default: begin
              p_dis = 1'b1;
            end
          endcase
        end
      end
      FN_SELECT: begin
        sel_en = 1'b1;
      end
      FN_LOAD: begin
        wr_en = (wr_id < IDW'(NUM_SEQUENCES));
      end
      default: begin
      end
    endcase

    if (sel_en) begin
      if (sel_seq > SQ_LAST) begin
        p_dis = 1'b1;
      end else if (sel_seq == SQ_NONE) begin
        p_pending = SQ_NONE;
        if (phase_r == PH_IDLE) begin
          res.speed_write = 1'b1;
          res.speed_value = sel_spd;
        end
      end else if (sel_seq == SQ_UP) begin
        if (!up_r) begin
          p_pending = SQ_UP;
        end
        res.speed_write = 1'b1;
        res.speed_value = default_speed_r;
      end else if (sel_seq == SQ_DOWN) begin
        if (up_r) begin
          p_pending = SQ_DOWN;
        end
        res.speed_write = 1'b1;
        res.speed_value = default_speed_r;
      end else if (up_r) begin
        p_pending = sel_seq;
        if (sel_seq == SQ_DIRECT || sel_seq == SQ_REVERSE) begin
          res.trajectory_write = 1'b1;
          res.out_curvature    = sel_curv;
          res.out_stride       = sel_step;
        end else if (sel_seq == SQ_PUSH_PULL) begin
          res.trajectory_write = 1'b1;
          res.out_curvature    = PUSH_PULL_CURV;
          res.out_stride       = PUSH_PULL_STEP;
        end
        res.speed_write = 1'b1;
        res.speed_value = (sel_seq == SQ_DANCE) ? default_speed_r : sel_spd;
      end
    end

    res.fatal_error  = p_dis;
    res.body_up      = p_up;
    res.engine_phase = p_phase;
  end

  // ---- read address for the item entering the execute register ----
  // Use the active sequence as it stands after the item now executing.
  assign rd_seq = exec ? p_active : active_r;
  assign rd_id  = IDW'(rd_seq);
  assign rd_in  = (rd_id < IDW'(NUM_SEQUENCES));

  // ---- descriptor memory ----
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[wr_id[AW-1:0]] <= wr_word;
    end
    if (in_acc) begin
      rd_word_r <= mem[rd_id[AW-1:0]];
    end
  end

  // ---- forwarding and out-of-range read ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r   <= 1'b0;
      rd_zero_r <= 1'b0;
    end else if (in_acc) begin
      fwd_v_r   <= wr_fire && (wr_id == rd_id);
      rd_zero_r <= !rd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc || wr_fire) begin
      fwd_word_r <= wr_word;
    end
  end

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r  <= IDLE_TIMEOUT_RST;
      default_speed_r <= DEFAULT_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDLE_TIMEOUT:  idle_timeout_r  <= cfg_data;
        CFG_DEFAULT_SPEED: default_speed_r <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // ---- engine state ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      stage_r   <= ST_PREPARE;
      cnt_r     <= '0;
      active_r  <= SQ_DOWN;
      pending_r <= SQ_DOWN;
      up_r      <= 1'b0;
      last_r    <= '0;
      dis_r     <= 1'b0;
    end else if (exec) begin
      phase_r   <= p_phase;
      stage_r   <= p_stage;
      cnt_r     <= p_cnt;
      active_r  <= p_active;
      pending_r <= p_pending;
      up_r      <= p_up;
      last_r    <= p_last;
      dis_r     <= p_dis;
    end
  end

  // ---- pipeline registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (exec) begin
        s1_v_r <= 1'b0;
      end
      if (exec) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_data;
    end
    if (exec) begin
      out_r <= res;
    end
  end

`ifndef NO_ASSERTIONS
  // Once disabled, the engine stays disabled.
  a_dis_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    dis_r |=> dis_r)
    else $error("engine left the disabled state");

  // A tick in the move phase always leads to the wait phase.
  a_move_wait: assert property (@(posedge clk) disable iff (!rst_n)
    exec && s1_r.func == FN_TICK && !dis_r && phase_r == PH_MOVE |=> phase_r == PH_WAIT)
    else $error("move tick did not enter wait");

  // A held result reports the state that the engine still has.
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_r.fatal_error == dis_r && out_r.body_up == up_r &&
                out_r.engine_phase == phase_r)
    else $error("result status differs from engine state");

  // A pending motion start leaves the engine waiting for completion.
  a_start_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.start_motion |-> phase_r == PH_WAIT)
    else $error("motion start without wait phase");
`endif

endmodule
